// ----- rtl/cmeq_pkg.sv -----
// ============================================================================
// cmeq_pkg
// Shared types, constants and arithmetic steps for the cubemap to
// equirectangular texel lookup: face geometry, square root and CORDIC steps.
// ============================================================================
package cmeq_pkg;

    localparam int FACE_SIZE     = 2048;
    localparam int CORDIC_STAGES = 20;

    localparam int PIX_W   = 11;
    localparam int FACE_W  = 3;
    localparam int WID_W   = 14;
    localparam int HGT_W   = 13;
    localparam int COL_W   = 13;
    localparam int ROW_W   = 12;
    localparam int IDX_W   = 25;
    localparam int ANG_W   = 20;
    localparam int ACC_W   = 22;

    localparam int COORD_W  = $clog2(FACE_SIZE) + 3;
    localparam int VEC_W    = COORD_W + 18;
    localparam int SQ_IN_W  = 2 * COORD_W + 16;
    localparam int SQ_ITERS = SQ_IN_W / 2;
    localparam int SEG1     = (SQ_ITERS > CORDIC_STAGES) ? SQ_ITERS : CORDIC_STAGES;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENV_HEIGHT = 1'b1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 14'd4096;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd2048;
    localparam logic [WID_W-1:0] WIDTH_MAX    = 14'd8192;
    localparam logic [HGT_W-1:0] HEIGHT_MAX   = 13'd4096;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic signed [ACC_W-1:0] ANG_QUARTER = ACC_W'(262144);
    localparam logic signed [ACC_W:0]   ANG_HALF    = (ACC_W+1)'(524288);
    localparam logic signed [ACC_W:0]   ANG_ONE     = (ACC_W+1)'(1048576);

    typedef struct packed {
        logic signed [VEC_W-1:0] a;
        logic signed [VEC_W-1:0] b;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } t_cstate;

    typedef struct packed {
        logic [SQ_IN_W-1:0] v;
        logic [SQ_IN_W-1:0] res;
    } t_sqrt;

    function automatic logic signed [ACC_W-1:0] atan_turn(input int i);
        logic signed [ACC_W-1:0] t;
        case (i)
            0:       t = ACC_W'(131072);
            1:       t = ACC_W'(77376);
            2:       t = ACC_W'(40884);
            3:       t = ACC_W'(20753);
            4:       t = ACC_W'(10417);
            5:       t = ACC_W'(5213);
            6:       t = ACC_W'(2607);
            7:       t = ACC_W'(1304);
            8:       t = ACC_W'(652);
            9:       t = ACC_W'(326);
            10:      t = ACC_W'(163);
            11:      t = ACC_W'(81);
            12:      t = ACC_W'(41);
            13:      t = ACC_W'(20);
            14:      t = ACC_W'(10);
            15:      t = ACC_W'(5);
            16:      t = ACC_W'(3);
            17:      t = ACC_W'(1);
            18:      t = ACC_W'(1);
            default: t = '0;
        endcase
        return t;
    endfunction

    // The vector is turned into the right half plane first.
    function automatic t_cstate cordic_init(input logic signed [VEC_W-1:0] a,
                                            input logic signed [VEC_W-1:0] b);
        t_cstate n;
        n.a    = a;
        n.b    = b;
        n.acc  = '0;
        n.zero = (a == '0) && (b == '0);
        if (b[VEC_W-1]) begin
            if (!a[VEC_W-1]) begin
                n.b   = a;
                n.a   = -b;
                n.acc = ANG_QUARTER;
            end else begin
                n.b   = -a;
                n.a   = b;
                n.acc = -ANG_QUARTER;
            end
        end
        return n;
    endfunction

    function automatic t_cstate cordic_step(input t_cstate s, input int i);
        logic signed [VEC_W-1:0] da;
        logic signed [VEC_W-1:0] db;
        t_cstate n;
        da = s.a >>> i;
        db = s.b >>> i;
        n  = s;
        if (!s.a[VEC_W-1]) begin
            n.b   = s.b + da;
            n.a   = s.a - db;
            n.acc = s.acc + atan_turn(i);
        end else begin
            n.b   = s.b - da;
            n.a   = s.a + db;
            n.acc = s.acc - atan_turn(i);
        end
        return n;
    endfunction

    function automatic logic signed [ACC_W-1:0] cordic_angle(input t_cstate s);
        return s.zero ? '0 : s.acc;
    endfunction

    function automatic t_sqrt sqrt_step(input t_sqrt s, input int k);
        logic [SQ_IN_W-1:0] bitv;
        logic [SQ_IN_W-1:0] trial;
        t_sqrt n;
        bitv  = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
        trial = s.res + bitv;
        if (s.v >= trial) begin
            n.v   = s.v - trial;
            n.res = (s.res >> 1) + bitv;
        end else begin
            n.v   = s.v;
            n.res = s.res >> 1;
        end
        return n;
    endfunction

    function automatic logic [ANG_W:0] ang_clamp(input logic signed [ACC_W:0] x);
        logic [ANG_W:0] r;
        if (x[ACC_W]) begin
            r = '0;
        end else if (x > ANG_ONE) begin
            r = ANG_ONE[ANG_W:0];
        end else begin
            r = x[ANG_W:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/cmeq_if.sv -----
// ============================================================================
// cmeq channel interfaces
// Valid/ready channels for cube pixels, source texels and register writes.
// ============================================================================
interface cmeq_pix_if;
    logic                         valid;
    logic                         ready;
    logic [cmeq_pkg::FACE_W-1:0]  face;
    logic [cmeq_pkg::PIX_W-1:0]   col;
    logic [cmeq_pkg::PIX_W-1:0]   row;
    modport source (output valid, face, col, row, input ready);
    modport sink   (input valid, face, col, row, output ready);
endinterface

interface cmeq_src_if;
    logic                         valid;
    logic                         ready;
    logic [cmeq_pkg::COL_W-1:0]   src_col;
    logic [cmeq_pkg::ROW_W-1:0]   src_row;
    logic [cmeq_pkg::IDX_W-1:0]   texel_index;
    logic                         face_error;
    modport source (output valid, src_col, src_row, texel_index, face_error, input ready);
    modport sink   (input valid, src_col, src_row, texel_index, face_error, output ready);
endinterface

interface cmeq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cmeq_pkg::CFG_IDX_W-1:0]  index;
    logic [cmeq_pkg::WID_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/cubemap_to_equirect_texel_index_unit.sv -----
// ============================================================================
// cubemap_to_equirect_texel_index_unit
// Maps a cube face pixel to the nearest texel of an equirectangular image
// through a square root and two CORDIC angle pipelines.
// ============================================================================
// Channel   Direction  Payload
// i_pix     in         face, col, row
// o_src     out        src_col, src_row, texel_index, face_error
// i_cfg     in         index, data (register write)
//
// One transfer is accepted per clock unless the output stalls the pipeline;
// the pipeline holds the 22 square root stages running beside the first CORDIC
// and the 20 stages of the second CORDIC. Each stage holds only while it is
// full and the stage after it holds, so bubbles close up during a stall.
// Register writes are taken every cycle. Reset empties the pipeline and
// loads the default image size of 4096 by 2048.
module cubemap_to_equirect_texel_index_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cmeq_pix_if.sink   i_pix,
    cmeq_src_if.source o_src,
    cmeq_cfg_if.sink   i_cfg
);

    localparam int CS     = cmeq_pkg::CORDIC_STAGES;
    localparam int SEG1   = cmeq_pkg::SEG1;
    localparam int CW     = cmeq_pkg::COORD_W;
    localparam int VW     = cmeq_pkg::VEC_W;
    localparam int AW     = cmeq_pkg::ACC_W;
    localparam int QW     = cmeq_pkg::SQ_IN_W;
    localparam int S_SEG1 = 1;
    localparam int S_SEG2 = S_SEG1 + SEG1 + 1;
    localparam int S_MUL  = S_SEG2 + CS + 1;
    localparam int S_CLP  = S_MUL + 1;
    localparam int S_OUT  = S_CLP + 1;
    localparam int NS     = S_OUT + 1;

    localparam logic signed [CW-1:0] N_S = CW'(cmeq_pkg::FACE_SIZE);

    logic [cmeq_pkg::WID_W-1:0] r_env_width;
    logic [cmeq_pkg::HGT_W-1:0] r_env_height;
    logic [cmeq_pkg::WID_W-1:0] w_eff;
    logic [cmeq_pkg::HGT_W-1:0] h_eff;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] adv;

    logic signed [CW-1:0] r_dx, r_dy, r_dz;
    logic                 r_err;
    logic signed [CW-1:0] s_val, t_val, n_dx, n_dy, n_dz;
    logic                 n_err;

    cmeq_pkg::t_cstate    r_c1 [SEG1+1];
    cmeq_pkg::t_sqrt      r_sq [SEG1+1];
    logic signed [CW-1:0] r_dy1 [SEG1+1];
    logic                 r_err1 [SEG1+1];

    cmeq_pkg::t_cstate             r_c2 [CS+1];
    logic [cmeq_pkg::ANG_W:0]      r_u [CS+1];
    logic                          r_err2 [CS+1];

    logic [cmeq_pkg::WID_W:0]      r_kc;
    logic [cmeq_pkg::WID_W-1:0]    r_kr;
    logic                          r_err_m;
    logic [cmeq_pkg::COL_W-1:0]    r_pc;
    logic [cmeq_pkg::ROW_W-1:0]    r_pr;
    logic [cmeq_pkg::ROW_W+cmeq_pkg::WID_W-1:0] r_prw;
    logic                          r_err_c;
    logic [cmeq_pkg::COL_W-1:0]    r_out_col;
    logic [cmeq_pkg::ROW_W-1:0]    r_out_row;
    logic [cmeq_pkg::IDX_W-1:0]    r_out_idx;
    logic                          r_out_err;

    logic signed [2*CW-1:0]        sq_x, sq_z;
    logic [2*CW-1:0]               sq_sum;
    logic [QW/2-1:0]               root;
    logic [cmeq_pkg::ANG_W:0]      v_ang;
    logic [cmeq_pkg::ANG_W+cmeq_pkg::WID_W:0]  prod_c;
    logic [cmeq_pkg::ANG_W+cmeq_pkg::HGT_W:0]  prod_r;
    logic [cmeq_pkg::IDX_W:0]      idx_sum;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_width  <= cmeq_pkg::WIDTH_RESET;
            r_env_height <= cmeq_pkg::HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cmeq_pkg::CFG_ENV_WIDTH:  r_env_width  <= i_cfg.data;
                cmeq_pkg::CFG_ENV_HEIGHT: r_env_height <= i_cfg.data[cmeq_pkg::HGT_W-1:0];
                default:                  r_env_width  <= r_env_width;
            endcase
        end
    end

    always_comb begin
        if (r_env_width == '0) begin
            w_eff = cmeq_pkg::WID_W'(1);
        end else if (r_env_width > cmeq_pkg::WIDTH_MAX) begin
            w_eff = cmeq_pkg::WIDTH_MAX;
        end else begin
            w_eff = r_env_width;
        end
        if (r_env_height == '0) begin
            h_eff = cmeq_pkg::HGT_W'(1);
        end else if (r_env_height > cmeq_pkg::HEIGHT_MAX) begin
            h_eff = cmeq_pkg::HEIGHT_MAX;
        end else begin
            h_eff = r_env_height;
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        adv[NS-1] = !r_vld[NS-1] || o_src.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_pix.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Face decode into an integer direction.
    always_comb begin
        s_val = signed'(CW'({i_pix.col, 1'b1})) - N_S;
        t_val = N_S - signed'(CW'({i_pix.row, 1'b1}));
        n_err = 1'b0;
        n_dx  = s_val;
        n_dy  = t_val;
        n_dz  = N_S;
        unique case (i_pix.face)
            cmeq_pkg::FACE_POS_X: begin n_dx = N_S;    n_dy = t_val;  n_dz = -s_val; end
            cmeq_pkg::FACE_NEG_X: begin n_dx = -N_S;   n_dy = t_val;  n_dz = s_val;  end
            cmeq_pkg::FACE_POS_Y: begin n_dx = s_val;  n_dy = N_S;    n_dz = t_val;  end
            cmeq_pkg::FACE_NEG_Y: begin n_dx = s_val;  n_dy = -N_S;   n_dz = -t_val; end
            cmeq_pkg::FACE_POS_Z: begin n_dx = s_val;  n_dy = t_val;  n_dz = N_S;    end
            cmeq_pkg::FACE_NEG_Z: begin n_dx = -s_val; n_dy = t_val;  n_dz = -N_S;   end
            default:              n_err = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dz  <= n_dz;
            r_err <= n_err;
        end
    end

    // Squares for the horizontal radius and entry of the longitude CORDIC.
    always_comb begin
        sq_x   = r_dx * r_dx;
        sq_z   = r_dz * r_dz;
        sq_sum = unsigned'(sq_x) + unsigned'(sq_z);
    end

    always_ff @(posedge i_clk) begin
        if (adv[S_SEG1]) begin
            r_c1[0]    <= cmeq_pkg::cordic_init(VW'(r_dz) <<< 16, VW'(r_dx) <<< 16);
            r_sq[0].v  <= {sq_sum, 16'd0};
            r_sq[0].res <= '0;
            r_dy1[0]   <= r_dy;
            r_err1[0]  <= r_err;
        end
    end

    for (genvar j = 0; j < SEG1; j++) begin : g_seg1
        always_ff @(posedge i_clk) begin
            if (adv[S_SEG1+1+j]) begin
                r_c1[j+1]   <= (j < CS) ? cmeq_pkg::cordic_step(r_c1[j], j) : r_c1[j];
                r_sq[j+1]   <= (j < cmeq_pkg::SQ_ITERS) ? cmeq_pkg::sqrt_step(r_sq[j], j)
                                                         : r_sq[j];
                r_dy1[j+1]  <= r_dy1[j];
                r_err1[j+1] <= r_err1[j];
            end
        end
    end

    // Column angle is ready; the colatitude CORDIC starts from the root.
    assign root = r_sq[SEG1].res[QW/2-1:0];

    always_ff @(posedge i_clk) begin
        if (adv[S_SEG2]) begin
            r_c2[0]   <= cmeq_pkg::cordic_init(VW'(root) <<< 8, VW'(r_dy1[SEG1]) <<< 16);
            r_u[0]    <= cmeq_pkg::ang_clamp((AW+1)'(cmeq_pkg::cordic_angle(r_c1[SEG1]))
                                             + cmeq_pkg::ANG_HALF);
            r_err2[0] <= r_err1[SEG1];
        end
    end

    for (genvar j = 0; j < CS; j++) begin : g_seg2
        always_ff @(posedge i_clk) begin
            if (adv[S_SEG2+1+j]) begin
                r_c2[j+1]   <= cmeq_pkg::cordic_step(r_c2[j], j);
                r_u[j+1]    <= r_u[j];
                r_err2[j+1] <= r_err2[j];
            end
        end
    end

    always_comb begin
        v_ang  = cmeq_pkg::ang_clamp({cmeq_pkg::cordic_angle(r_c2[CS]), 1'b0});
        prod_c = r_u[CS] * w_eff;
        prod_r = v_ang * h_eff;
    end

    always_ff @(posedge i_clk) begin
        if (adv[S_MUL]) begin
            r_kc    <= prod_c[cmeq_pkg::ANG_W+cmeq_pkg::WID_W:cmeq_pkg::ANG_W];
            r_kr    <= prod_r[cmeq_pkg::ANG_W+cmeq_pkg::HGT_W:cmeq_pkg::ANG_W];
            r_err_m <= r_err2[CS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[S_CLP]) begin
            if (r_kc >= (cmeq_pkg::WID_W+1)'(w_eff)) begin
                r_pc <= cmeq_pkg::COL_W'(w_eff - 1'b1);
            end else begin
                r_pc <= r_kc[cmeq_pkg::COL_W-1:0];
            end
            if (r_kr >= cmeq_pkg::WID_W'(h_eff)) begin
                r_pr  <= cmeq_pkg::ROW_W'(h_eff - 1'b1);
                r_prw <= cmeq_pkg::ROW_W'(h_eff - 1'b1) * w_eff;
            end else begin
                r_pr  <= r_kr[cmeq_pkg::ROW_W-1:0];
                r_prw <= r_kr[cmeq_pkg::ROW_W-1:0] * w_eff;
            end
            r_err_c <= r_err_m;
        end
    end

    assign idx_sum = (cmeq_pkg::IDX_W+1)'(r_prw) + (cmeq_pkg::IDX_W+1)'(r_pc);

    always_ff @(posedge i_clk) begin
        if (adv[S_OUT]) begin
            r_out_err <= r_err_c;
            if (r_err_c) begin
                r_out_col <= '0;
                r_out_row <= '0;
                r_out_idx <= '0;
            end else begin
                r_out_col <= r_pc;
                r_out_row <= r_pr;
                r_out_idx <= idx_sum[cmeq_pkg::IDX_W-1:0];
            end
        end
    end

    assign o_src.valid       = r_vld[NS-1];
    assign o_src.src_col     = r_out_col;
    assign o_src.src_row     = r_out_row;
    assign o_src.texel_index = r_out_idx;
    assign o_src.face_error  = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.valid && o_src.face_error |->
            o_src.src_col == '0 && o_src.src_row == '0 && o_src.texel_index == '0)
        else $error("face error result carries nonzero fields");

    a_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.valid && !o_src.face_error |->
            (14'(o_src.src_col) < w_eff) && (13'(o_src.src_row) < h_eff))
        else $error("source texel outside the image");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.valid && !o_src.face_error |->
            o_src.texel_index == 25'(o_src.src_row * w_eff + o_src.src_col))
        else $error("texel index does not match row and column");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_src.ready |-> i_pix.ready)
        else $error("input stalled while the output side takes transfers");

endmodule
